/* hdl/yuyv_to_rgb_converter_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the YUYV to RGB converter
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef YUYV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH
`define YUYV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define Y2R_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("y2r assertion failed");

// Next-cycle implication
`define Y2R_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("y2r assertion failed");

`else

`define Y2R_ASSERT_IMPL(label, ante, cons)
`define Y2R_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hdl/y2r_pkg.sv */
// ----------------------------------------------------------------------------
// y2r_pkg
// Types, coefficients and the floor/clamp helper for the YUYV to RGB converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

    localparam int FRAC_BITS = 14;
    localparam int SUM_W     = 24;
    localparam int CHAN_W    = 8;

    // Q2.14 coefficients
    localparam logic signed [SUM_W-1:0] COEF_RV = 24'sd23044;
    localparam logic signed [SUM_W-1:0] COEF_GU = 24'sd5661;
    localparam logic signed [SUM_W-1:0] COEF_GV = 24'sd11746;
    localparam logic signed [SUM_W-1:0] COEF_BU = 24'sd29147;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    typedef logic signed [SUM_W-1:0] sum_t;

    // Chroma contributions shared by both pixels of a macropixel
    typedef struct packed {
        sum_t rv;
        sum_t guv;
        sum_t bu;
    } chroma_terms_t;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } rgb_t;

    // Floor-shift by the fraction width, then saturate to 0..255
    function automatic logic [CHAN_W-1:0] floor_clamp(input sum_t sum);
        logic signed [SUM_W-FRAC_BITS-1:0] q;
        q = sum[SUM_W-1:FRAC_BITS];
        if (q[SUM_W-FRAC_BITS-1])
            return '0;
        else if (q[SUM_W-FRAC_BITS-2:CHAN_W] != '0)
            return CHAN_MAX;
        else
            return q[CHAN_W-1:0];
    endfunction

endpackage

/* hdl/y2r_chroma.sv */
// ----------------------------------------------------------------------------
// y2r_chroma
// Removes the chroma offset and forms the coefficient products for Cb and Cr.
// ----------------------------------------------------------------------------
module y2r_chroma
(
    input  logic [7:0]             chroma_blue,
    input  logic [7:0]             chroma_red,
    output y2r_pkg::chroma_terms_t terms
);

    logic signed [8:0] u;
    logic signed [8:0] v;
    y2r_pkg::sum_t     u_ext;
    y2r_pkg::sum_t     v_ext;

    // Subtracting 128 from a byte is a flip of its top bit, read as signed
    assign u = $signed({~chroma_blue[7], ~chroma_blue[7], chroma_blue[6:0]});
    assign v = $signed({~chroma_red[7], ~chroma_red[7], chroma_red[6:0]});

    assign u_ext = {{(y2r_pkg::SUM_W-9){u[8]}}, u};
    assign v_ext = {{(y2r_pkg::SUM_W-9){v[8]}}, v};

    assign terms.rv  = y2r_pkg::sum_t'(v_ext * y2r_pkg::COEF_RV);
    assign terms.guv = y2r_pkg::sum_t'(u_ext * y2r_pkg::COEF_GU + v_ext * y2r_pkg::COEF_GV);
    assign terms.bu  = y2r_pkg::sum_t'(u_ext * y2r_pkg::COEF_BU);

endmodule

/* hdl/y2r_pixel.sv */
// ----------------------------------------------------------------------------
// y2r_pixel
// Adds scaled luma to the shared chroma terms and clamps each channel.
// ----------------------------------------------------------------------------
module y2r_pixel
(
    input  logic [7:0]             luma,
    input  y2r_pkg::chroma_terms_t terms,
    output y2r_pkg::rgb_t          rgb
);

    y2r_pkg::sum_t ys;

    assign ys = $signed({{(y2r_pkg::SUM_W-8-y2r_pkg::FRAC_BITS){1'b0}}, luma,
                         {y2r_pkg::FRAC_BITS{1'b0}}});

    assign rgb.r = y2r_pkg::floor_clamp(y2r_pkg::sum_t'(ys + terms.rv));
    assign rgb.g = y2r_pkg::floor_clamp(y2r_pkg::sum_t'(ys - terms.guv));
    assign rgb.b = y2r_pkg::floor_clamp(y2r_pkg::sum_t'(ys + terms.bu));

endmodule

/* hdl/yuyv_to_rgb_converter_unit.sv */
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter_unit
// Converts one YUYV macropixel into two RGB888 pixels per transaction.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  input   | in_valid / in_stall | luma_first, chroma_blue, luma_second,
//          |                     | chroma_red
//  output  | out_valid/out_stall | red_/green_/blue_first, red_/green_/blue_second
//
//  Two register stages: input register, then result register; the products,
//  sums and clamps sit between them. Throughput is one transaction per cycle
//  while out_stall is low. The input register also serves as the skid stage,
//  so in_stall rises only when both stages hold data and out_stall is high.
//  Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
`include "yuyv_to_rgb_converter_unit_assert.svh"

module yuyv_to_rgb_converter_unit
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] luma_first,
    input  logic [7:0] chroma_blue,
    input  logic [7:0] luma_second,
    input  logic [7:0] chroma_red,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] red_first,
    output logic [7:0] green_first,
    output logic [7:0] blue_first,
    output logic [7:0] red_second,
    output logic [7:0] green_second,
    output logic [7:0] blue_second
);

    logic       s1_valid_reg, s1_valid_next;
    logic       s2_valid_reg, s2_valid_next;
    logic [7:0] y0_reg, cb_reg, y1_reg, cr_reg;
    logic       s1_load;
    logic       s2_load;

    y2r_pkg::chroma_terms_t terms;
    y2r_pkg::rgb_t          pix0, pix1;
    y2r_pkg::rgb_t          pix0_reg, pix1_reg;

    // Result stage frees up when empty or being taken
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && s2_valid_reg && out_stall;
    assign s1_load  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
            s1_valid_next = 1'b1;
        else if (s2_load)
            s1_valid_next = 1'b0;

        s2_valid_next = s2_valid_reg;
        if (s2_load)
            s2_valid_next = 1'b1;
        else if (!out_stall)
            s2_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            y0_reg <= luma_first;
            cb_reg <= chroma_blue;
            y1_reg <= luma_second;
            cr_reg <= chroma_red;
        end
    end

    y2r_chroma u_chroma
    (
        .chroma_blue (cb_reg),
        .chroma_red  (cr_reg),
        .terms       (terms)
    );

    y2r_pixel u_pixel_first
    (
        .luma  (y0_reg),
        .terms (terms),
        .rgb   (pix0)
    );

    y2r_pixel u_pixel_second
    (
        .luma  (y1_reg),
        .terms (terms),
        .rgb   (pix1)
    );

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            pix0_reg <= pix0;
            pix1_reg <= pix1;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign red_first    = pix0_reg.r;
    assign green_first  = pix0_reg.g;
    assign blue_first   = pix0_reg.b;
    assign red_second   = pix1_reg.r;
    assign green_second = pix1_reg.g;
    assign blue_second  = pix1_reg.b;

    // An accepted transaction always lands in the input register
    `Y2R_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, s1_valid_reg)
    // Upstream is held off only when both stages are full
    `Y2R_ASSERT_IMPL(a_stall_only_when_full, in_stall, s1_valid_reg && s2_valid_reg)
    // A waiting input stage moves into an empty result stage
    `Y2R_ASSERT_NEXT(a_s1_drains_to_s2, s1_valid_reg && !s2_valid_reg, s2_valid_reg)
    // A taken result with nothing behind it leaves the output empty
    `Y2R_ASSERT_NEXT(a_output_empties, s2_valid_reg && !out_stall && !s1_valid_reg,
                     !s2_valid_reg)

endmodule
